// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the turtle command engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// Turtle command engine package
// Types, codes, constants and tables shared by the engine modules.
// ----------------------------------------------------------------------------
package tce_pkg;

   localparam int StackDepth = 64;
   localparam int CordicSteps = 30;
   localparam logic [31:0] CordicGain = 32'd652032874;
   localparam logic [15:0] TurnReset = 16'd21845;
   localparam logic [31:0] LengthReset = 32'd4718592;
   localparam int QueueDepth = 2;

   typedef enum logic [3:0] {
      OP_BEGIN = 4'd0, OP_DRAW = 4'd1, OP_MOVE = 4'd2, OP_TURN_PLUS = 4'd3,
      OP_TURN_MINUS = 4'd4, OP_PUSH = 4'd5, OP_POP = 4'd6, OP_COLOR_UP = 4'd7,
      OP_COLOR_DOWN = 4'd8, OP_SET_COLOR = 4'd9, OP_MUL = 4'd10, OP_DIV = 4'd11,
      OP_MUL_SQRT = 4'd12, OP_DIV_SQRT = 4'd13, OP_FLIP = 4'd14, OP_REVERSE = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_SEGMENT = 3'd0, KIND_COLOR = 3'd1, KIND_ZERO_DIV = 3'd2,
      KIND_OVERFLOW = 3'd3, KIND_EMPTY_POP = 3'd4
   } result_kind_type;

   typedef enum logic [0:0] {
      CSR_TURN_ANGLE = 1'd0, CSR_INITIAL_LENGTH = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [7:0]  color_count;
      logic [31:0] scale_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic signed [31:0] x_start;
      logic signed [31:0] y_start;
      logic signed [31:0] x_end;
      logic signed [31:0] y_end;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      opcode_type  op;
      logic [7:0]  color_count;
      logic [31:0] scale_value;
      logic        zero_scale;
   } cmd_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
         5'd20: v = 32'd652;       5'd21: v = 32'd326;
         5'd22: v = 32'd163;       5'd23: v = 32'd81;
         5'd24: v = 32'd41;        5'd25: v = 32'd20;
         5'd26: v = 32'd10;        5'd27: v = 32'd5;
         5'd28: v = 32'd3;         5'd29: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   localparam logic [23:0] PaletteRgb [256] = '{
      24'hb8870b, 24'hb38a0a, 24'hae8d0a, 24'ha9900a, 24'ha49309, 24'h9f9709, 24'h9a9a09,
      24'h959d08, 24'h90a008, 24'h8ba408, 24'h86a708, 24'h81aa07, 24'h7cad07, 24'h77b107,
      24'h72b406, 24'h6db706, 24'h68ba06, 24'h63be05, 24'h5ec105, 24'h59c405, 24'h54c705,
      24'h4fcb04, 24'h4ace04, 24'h45d104, 24'h40d403, 24'h3bd803, 24'h36db03, 24'h31de02,
      24'h2ce102, 24'h27e502, 24'h22e802, 24'h1deb01, 24'h18ee01, 24'h13f201, 24'h0ef500,
      24'h09f800, 24'h04fb00, 24'h00ff00, 24'h01fa06, 24'h03f60c, 24'h05f212, 24'h07ee18,
      24'h08ea1e, 24'h0ae624, 24'h0ce22a, 24'h0ede30, 24'h0fda36, 24'h11d63c, 24'h13d242,
      24'h15ce48, 24'h16ca4f, 24'h18c655, 24'h1ac25b, 24'h1cbe61, 24'h1dba67, 24'h1fb66d,
      24'h21b173, 24'h23ad79, 24'h24a97f, 24'h26a585, 24'h28a18b, 24'h2a9d91, 24'h2b9998,
      24'h2d959e, 24'h2f91a4, 24'h318daa, 24'h3289b0, 24'h3485b6, 24'h3681bc, 24'h387dc2,
      24'h3979c8, 24'h3b75ce, 24'h3d71d4, 24'h3f6dda, 24'h4169e1, 24'h4166de, 24'h4163db,
      24'h4160d9, 24'h425dd6, 24'h425ad4, 24'h4257d1, 24'h4355cf, 24'h4352cc, 24'h434fc9,
      24'h434cc7, 24'h4449c4, 24'h4446c2, 24'h4444bf, 24'h4541bd, 24'h453eba, 24'h453bb7,
      24'h4638b5, 24'h4635b2, 24'h4633b0, 24'h4630ad, 24'h472dab, 24'h472aa8, 24'h4727a5,
      24'h4824a3, 24'h4822a0, 24'h481f9e, 24'h491c9b, 24'h491999, 24'h491696, 24'h491393,
      24'h4a1191, 24'h4a0e8e, 24'h4a0b8c, 24'h4b0889, 24'h4b0587, 24'h4b0284, 24'h4c0082,
      24'h500384, 24'h540787, 24'h590a8a, 24'h5d0e8d, 24'h611190, 24'h661593, 24'h6a1896,
      24'h6f1c99, 24'h731f9c, 24'h77239f, 24'h7c26a2, 24'h802aa5, 24'h842da7, 24'h8931aa,
      24'h8d34ad, 24'h9238b0, 24'h963bb3, 24'h9a3fb6, 24'h9f42b9, 24'ha346bc, 24'ha749bf,
      24'hac4dc2, 24'hb050c5, 24'hb554c8, 24'hb957ca, 24'hbd5bcd, 24'hc25ed0, 24'hc662d3,
      24'hca65d6, 24'hcf69d9, 24'hd36cdc, 24'hd870df, 24'hdc73e2, 24'he077e5, 24'he57ae8,
      24'he97eeb, 24'hee82ee, 24'hee7ee7, 24'hee7ae0, 24'hef77da, 24'hef73d3, 24'hf06fcc,
      24'hf06cc6, 24'hf168bf, 24'hf165b9, 24'hf261b2, 24'hf25dab, 24'hf35aa5, 24'hf3569e,
      24'hf45398, 24'hf44f91, 24'hf54b8a, 24'hf54884, 24'hf6447d, 24'hf64177, 24'hf63d70,
      24'hf73969, 24'hf73663, 24'hf8325c, 24'hf82e55, 24'hf92b4f, 24'hf92748, 24'hfa2442,
      24'hfa203b, 24'hfb1c34, 24'hfb192e, 24'hfc1527, 24'hfc1221, 24'hfd0e1a, 24'hfd0a13,
      24'hfe070d, 24'hfe0306, 24'hff0000, 24'hff0400, 24'hff0900, 24'hff0d00, 24'hff1200,
      24'hff1700, 24'hff1b00, 24'hff2000, 24'hff2400, 24'hff2900, 24'hff2e00, 24'hff3200,
      24'hff3700, 24'hff3b00, 24'hff4000, 24'hff4500, 24'hff4900, 24'hff4e00, 24'hff5300,
      24'hff5700, 24'hff5c00, 24'hff6000, 24'hff6500, 24'hff6a00, 24'hff6e00, 24'hff7300,
      24'hff7700, 24'hff7c00, 24'hff8100, 24'hff8500, 24'hff8a00, 24'hff8e00, 24'hff9300,
      24'hff9800, 24'hff9c00, 24'hffa100, 24'hffa600, 24'hfda500, 24'hfba400, 24'hf9a300,
      24'hf7a201, 24'hf5a101, 24'hf3a001, 24'hf19f02, 24'hef9f02, 24'hed9e02, 24'heb9d03,
      24'he99c03, 24'he79b03, 24'he59a03, 24'he39904, 24'he19904, 24'hdf9804, 24'hdd9705,
      24'hdb9605, 24'hd99505, 24'hd79406, 24'hd59306, 24'hd39306, 24'hd19207, 24'hcf9107,
      24'hcd9007, 24'hcb8f07, 24'hc98e08, 24'hc78d08, 24'hc58d08, 24'hc38c09, 24'hc18b09,
      24'hbf8a09, 24'hbd890a, 24'hbb880a, 24'hb9870a
   };

endpackage

// File: hw/rtl/tce_front.sv
// ----------------------------------------------------------------------------
// Turtle command front end
// Accepts request items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module tce_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tce_pkg::req_type   req_data,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output tce_pkg::cmd_type   cmd_data
);

   localparam int QW = $clog2(tce_pkg::QueueDepth);

   tce_pkg::cmd_type        queue_ff [tce_pkg::QueueDepth];
   logic [QW-1:0]           wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QW:0]             count_ff, count_in;
   tce_pkg::cmd_type        cmd_new;
   logic                    push, pop;

   assign req_ready = (count_ff != (QW+1)'(tce_pkg::QueueDepth)) ? 1'b1 : 1'b0;
   assign push = req_valid && req_ready;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data = queue_ff[rd_ptr_ff];

   always_comb begin
      cmd_new.op = tce_pkg::opcode_type'(req_data.opcode);
      cmd_new.color_count = req_data.color_count;
      cmd_new.scale_value = req_data.scale_value;
      cmd_new.zero_scale = (req_data.scale_value == 32'd0);
      wr_ptr_in = push ? QW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = (QW+1)'(count_ff + {{QW{1'b0}}, push} - {{QW{1'b0}}, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: hw/rtl/tce_divider.sv
// ----------------------------------------------------------------------------
// Turtle length divider and square root
// Shared bit-serial unit: restoring division, or square root (one bit a cycle).
// ----------------------------------------------------------------------------
module tce_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start_div,
   input  logic        start_sqrt,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   input  logic [47:0] radicand,
   output logic        done,
   output logic [47:0] result
);

   logic        busy_ff, busy_in, sqrt_ff, sqrt_in;
   logic [5:0]  step_ff, step_in;
   logic [47:0] num_ff, num_in, quo_ff, quo_in;
   logic [49:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [49:0] trial;
   logic [49:0] rem_sh;

   assign done = busy_ff && (step_ff == 6'd1);
   assign result = quo_in;

   always_comb begin
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      step_in = step_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      rem_sh = '0;
      trial = '0;
      if (start_div || start_sqrt) begin
         busy_in = 1'b1;
         sqrt_in = start_sqrt;
         num_in = start_sqrt ? radicand : dividend;
         den_in = divisor;
         quo_in = '0;
         rem_in = '0;
         step_in = start_sqrt ? 6'd24 : 6'd48;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            rem_sh = {rem_ff[47:0], num_ff[47:46]};
            trial = rem_sh - {quo_ff[47:0], 2'b01};
            num_in = {num_ff[45:0], 2'b00};
            if (!trial[49]) begin
               rem_in = trial;
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end else begin
            rem_sh = {rem_ff[48:0], num_ff[47]};
            trial = rem_sh - {18'd0, den_ff};
            num_in = {num_ff[46:0], 1'b0};
            if (!trial[49]) begin
               rem_in = trial;
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end
         step_in = step_ff - 6'd1;
         if (step_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      sqrt_ff <= sqrt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// File: hw/rtl/tce_back.sv
// ----------------------------------------------------------------------------
// Turtle command back end
// Carries out queued commands: turtle state, CORDIC, scaling, save stack.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tce_back #(
   parameter int STACK_DEPTH = tce_pkg::StackDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  tce_pkg::cmd_type   cmd_data,
   input  logic [15:0]        turn_angle,
   input  logic [31:0]        initial_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tce_pkg::rsp_type   rsp_data
);

   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_CORDIC = 10'b0000000010,
      ST_MULX   = 10'b0000000100,
      ST_ADV    = 10'b0000001000,
      ST_SQRT   = 10'b0000010000,
      ST_MUL    = 10'b0000100000,
      ST_DIV    = 10'b0001000000,
      ST_WAIT   = 10'b0010000000,
      ST_POP    = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] len;
      logic [15:0] hd;
      logic [7:0]  pal;
      logic        ccw;
   } saved_type;

   state_type         state_ff, state_in;
   tce_pkg::cmd_type  cmd_ff, cmd_in;
   logic [31:0]       pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, len_ff, len_in;
   logic [15:0]       heading_ff, heading_in;
   logic [7:0]        pal_ff, pal_in;
   logic              ccw_ff, ccw_in, err_ff, err_in;
   logic [CW-1:0]     count_ff, count_in;
   saved_type         stack_mem [STACK_DEPTH];
   saved_type         stack_rd_ff;
   logic              stack_we;
   logic [SW-1:0]     stack_wa, stack_ra;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] z_ff, z_in;
   logic              flip_ff, flip_in;
   logic [4:0]        it_ff, it_in;
   logic signed [66:0] px_prod_ff, px_prod_in, py_prod_ff, py_prod_in;
   logic [47:0]       root_ff, root_in;
   logic [63:0]       mul_prod;
   logic              rsp_valid_ff, rsp_valid_in;
   tce_pkg::rsp_type  rsp_ff, rsp_in, out_ff, out_in;
   logic              div_start, sqrt_start, div_done;
   logic [47:0]       div_result;
   logic [31:0]       div_den;
   logic [31:0]       ang;
   logic signed [33:0] shx, shy, atn;
   logic signed [66:0] rx, ry;

   function automatic logic [31:0] sat32(input logic [79:0] v);
      return (v[79:32] != '0) ? 32'hFFFFFFFF : v[31:0];
   endfunction

   function automatic tce_pkg::rsp_type color_rsp(input logic [7:0] idx);
      tce_pkg::rsp_type r;
      r = '0;
      r.result_kind = tce_pkg::KIND_COLOR;
      {r.red, r.green, r.blue} = tce_pkg::PaletteRgb[idx];
      return r;
   endfunction

   tce_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .start_div  (div_start),
      .start_sqrt (sqrt_start),
      .dividend   ({len_ff, 16'd0}),
      .divisor    (div_den),
      .radicand   ({cmd_ff.scale_value, 16'd0}),
      .done       (div_done),
      .result     (div_result)
   );

   assign div_den = (cmd_ff.op == tce_pkg::OP_DIV) ? cmd_ff.scale_value : root_ff[31:0];
   assign cmd_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = out_ff;
   assign mul_prod = {32'd0, len_ff} * {32'd0, root_ff[31:0]};
   assign stack_wa = SW'(count_ff);
   assign stack_ra = SW'(count_ff - CW'(1));
   assign shx = cx_ff >>> it_ff;
   assign shy = cy_ff >>> it_ff;
   assign atn = 34'(signed'({2'b00, tce_pkg::atan_entry(it_ff)}));
   assign ang = {heading_ff, 16'd0};
   assign rx = 67'(signed'({1'b0, len_ff})) * 67'(cx_ff);
   assign ry = 67'(signed'({1'b0, len_ff})) * 67'(cy_ff);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      len_in = len_ff;
      heading_in = heading_ff;
      pal_in = pal_ff;
      ccw_in = ccw_ff;
      err_in = err_ff;
      count_in = count_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      it_in = it_ff;
      px_prod_in = px_prod_ff;
      py_prod_in = py_prod_ff;
      root_in = root_ff;
      rsp_in = rsp_ff;
      stack_we = 1'b0;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      out_in = out_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in = cmd_data;
               rsp_in = '0;
               if (cmd_data.op == tce_pkg::OP_BEGIN) begin
                  pos_x_in = '0;
                  pos_y_in = '0;
                  heading_in = '0;
                  len_in = initial_length;
                  pal_in = '0;
                  ccw_in = 1'b1;
                  count_in = '0;
                  err_in = 1'b0;
                  rsp_in = color_rsp(8'd0);
                  state_in = ST_OUT;
               end else if (!err_ff) begin
                  unique case (cmd_data.op)
                     tce_pkg::OP_DRAW, tce_pkg::OP_MOVE: begin
                        flip_in = ((ang + 32'h40000000) >= 32'h80000000);
                        z_in = 34'(signed'(flip_in ? ang + 32'h80000000 : ang));
                        cx_in = 34'(signed'({2'b00, tce_pkg::CordicGain}));
                        cy_in = '0;
                        it_in = '0;
                        state_in = ST_CORDIC;
                     end
                     tce_pkg::OP_TURN_PLUS:
                        heading_in = ccw_ff ? heading_ff + turn_angle
                                            : heading_ff - turn_angle;
                     tce_pkg::OP_TURN_MINUS:
                        heading_in = ccw_ff ? heading_ff - turn_angle
                                            : heading_ff + turn_angle;
                     tce_pkg::OP_PUSH: begin
                        if (count_ff >= CW'(STACK_DEPTH)) begin
                           err_in = 1'b1;
                           rsp_in.result_kind = tce_pkg::KIND_OVERFLOW;
                           state_in = ST_OUT;
                        end else begin
                           stack_we = 1'b1;
                           count_in = CW'(count_ff + 1'b1);
                        end
                     end
                     tce_pkg::OP_POP: begin
                        if (count_ff == '0) begin
                           rsp_in.result_kind = tce_pkg::KIND_EMPTY_POP;
                           state_in = ST_OUT;
                        end else begin
                           state_in = ST_POP;
                        end
                     end
                     tce_pkg::OP_COLOR_UP: begin
                        pal_in = pal_ff + cmd_data.color_count;
                        rsp_in = color_rsp(pal_in);
                        state_in = ST_OUT;
                     end
                     tce_pkg::OP_COLOR_DOWN: begin
                        pal_in = pal_ff - cmd_data.color_count;
                        rsp_in = color_rsp(pal_in);
                        state_in = ST_OUT;
                     end
                     tce_pkg::OP_SET_COLOR: begin
                        pal_in = cmd_data.color_count;
                        rsp_in = color_rsp(pal_in);
                        state_in = ST_OUT;
                     end
                     tce_pkg::OP_MUL: begin
                        root_in = {16'd0, cmd_data.scale_value};
                        state_in = ST_MUL;
                     end
                     tce_pkg::OP_DIV, tce_pkg::OP_DIV_SQRT: begin
                        if (cmd_data.zero_scale) begin
                           err_in = 1'b1;
                           rsp_in.result_kind = tce_pkg::KIND_ZERO_DIV;
                           state_in = ST_OUT;
                        end else begin
                           state_in = (cmd_data.op == tce_pkg::OP_DIV) ? ST_DIV : ST_SQRT;
                        end
                     end
                     tce_pkg::OP_MUL_SQRT: state_in = ST_SQRT;
                     tce_pkg::OP_FLIP: ccw_in = !ccw_ff;
                     tce_pkg::OP_REVERSE: heading_in = heading_ff + 16'h8000;
                     default: ;
                  endcase
               end
            end
         end
         ST_CORDIC: begin
            if (!z_ff[33]) begin
               cx_in = cx_ff - shy;
               cy_in = cy_ff + shx;
               z_in = z_ff - atn;
            end else begin
               cx_in = cx_ff + shy;
               cy_in = cy_ff - shx;
               z_in = z_ff + atn;
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(tce_pkg::CordicSteps - 1)) begin
               if (flip_ff) begin
                  cx_in = -cx_in;
                  cy_in = -cy_in;
               end
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            px_prod_in = rx + 67'sd536870912;
            py_prod_in = ry + 67'sd536870912;
            state_in = ST_ADV;
         end
         ST_ADV: begin
            pos_x_in = pos_x_ff + px_prod_ff[61:30];
            pos_y_in = pos_y_ff + py_prod_ff[61:30];
            if (cmd_ff.op == tce_pkg::OP_DRAW) begin
               rsp_in.result_kind = tce_pkg::KIND_SEGMENT;
               rsp_in.x_start = pos_x_ff;
               rsp_in.y_start = pos_y_ff;
               rsp_in.x_end = pos_x_in;
               rsp_in.y_end = pos_y_in;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQRT: begin
            sqrt_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               root_in = div_result;
               if (cmd_ff.op == tce_pkg::OP_MUL_SQRT) begin
                  state_in = ST_MUL;
               end else if (cmd_ff.op == tce_pkg::OP_DIV_SQRT) begin
                  state_in = ST_DIV;
                  cmd_in.op = tce_pkg::OP_REVERSE;
               end else begin
                  len_in = sat32({32'd0, div_result});
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MUL: begin
            len_in = sat32({32'd0, mul_prod[63:16]});
            state_in = ST_IDLE;
         end
         ST_POP: begin
            count_in = CW'(count_ff - 1'b1);
            pos_x_in = stack_rd_ff.px;
            pos_y_in = stack_rd_ff.py;
            len_in = stack_rd_ff.len;
            heading_in = stack_rd_ff.hd;
            pal_in = stack_rd_ff.pal;
            ccw_in = stack_rd_ff.ccw;
            rsp_in = color_rsp(stack_rd_ff.pal);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               out_in = rsp_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         len_ff <= tce_pkg::LengthReset;
         heading_ff <= '0;
         pal_ff <= '0;
         ccw_ff <= 1'b1;
         err_ff <= 1'b0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         len_ff <= len_in;
         heading_ff <= heading_in;
         pal_ff <= pal_in;
         ccw_ff <= ccw_in;
         err_ff <= err_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      it_ff <= it_in;
      px_prod_ff <= px_prod_in;
      py_prod_ff <= py_prod_in;
      root_ff <= root_in;
      rsp_ff <= rsp_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= {pos_x_ff, pos_y_ff, len_ff, heading_ff, pal_ff, ccw_ff};
      end
      stack_rd_ff <= stack_mem[stack_ra];
   end

   `ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(STACK_DEPTH),
      "stack count above depth")
   `ASSERT_NEXT(a_err_blocks_push, clock, reset,
      err_ff && state_ff == ST_IDLE && cmd_valid && cmd_data.op == tce_pkg::OP_PUSH,
      $stable(count_ff), "push taken while error set")
   `ASSERT_NEXT(a_begin_clears, clock, reset,
      state_ff == ST_IDLE && cmd_valid && cmd_ready && cmd_data.op == tce_pkg::OP_BEGIN,
      !err_ff && count_ff == '0, "begin did not clear turtle")

endmodule

// File: hw/rtl/turtle_command_engine_top.sv
// Sequencing: color/set/begin results go out through ST_OUT, pop through ST_POP and ST_OUT,
// draw through a 30-step CORDIC, ST_MULX, ST_ADV and ST_OUT; move, div, mul sqrt and div
// sqrt also occupy the back end (bit-serial divide/root unit), turn and flip do not.
// Throughput: one item at a time in the back end, which takes no new item while a
// result waits on rsp_ready; a 2-entry queue decouples intake.
// Reset: synchronous, active high; turtle and registers to defaults, stack empty.
// ----------------------------------------------------------------------------
// Turtle command engine top level
// Front end with command queue, back end turtle executor, CSR registers.
// ----------------------------------------------------------------------------
module turtle_command_engine_top #(
   parameter int STACK_DEPTH = tce_pkg::StackDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tce_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tce_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [15:0]       turn_angle_ff;
   logic [31:0]       init_len_ff;
   logic              cmd_valid, cmd_ready;
   tce_pkg::cmd_type  cmd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_angle_ff <= tce_pkg::TurnReset;
         init_len_ff <= tce_pkg::LengthReset;
      end else if (csr_valid) begin
         case (tce_pkg::csr_index_type'(csr_index))
            tce_pkg::CSR_TURN_ANGLE: turn_angle_ff <= csr_wdata[15:0];
            tce_pkg::CSR_INITIAL_LENGTH: init_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   tce_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_data       (cmd_data),
      .turn_angle     (turn_angle_ff),
      .initial_length (init_len_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule
